// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL top level, which carries the concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition holds at each rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) 1'b1 |-> (cond)) else $error(msg);

`endif

// ===== rtl/mtf_pkg.sv =====
// Constants and types shared by the move-to-front list modules.
`default_nettype none

package mtf_pkg;

  localparam int MAX_ITEMS = 128;
  localparam int SYM_W     = 8;
  localparam int POS_W     = 8;
  localparam int COST_W    = 32;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int GRP_SZ    = 8;
  localparam int GLOC_W    = $clog2(GRP_SZ);
  localparam int NGRP      = (MAX_ITEMS + GRP_SZ - 1) / GRP_SZ;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_ACCESS = 1'b1;

  // Broadcast control from the sequencer to every cell of the list.
  typedef struct packed {
    logic             cmp_en;
    logic             load_en;
    logic             move_en;
    logic [CNT_W-1:0] fill;
    logic [IDX_W-1:0] move_idx;
    logic [SYM_W-1:0] sym;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/mtf_cell.sv =====
// One list cell: holds and loads an entry, compares it against the search symbol and shifts.
`default_nettype none

module mtf_cell import mtf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic [SYM_W-1:0] left_i,
  output logic [SYM_W-1:0] entry_o,
  output logic             match_o
);

  logic [SYM_W-1:0] entry_q, entry_d;
  logic             match_q, match_d;
  logic             in_list;

  always_comb begin
    in_list = CNT_W'(idx_i) < ctrl_i.fill;
    entry_d = entry_q;
    if (ctrl_i.load_en && (CNT_W'(idx_i) == ctrl_i.fill)) begin
      entry_d = ctrl_i.sym;
    end else if (ctrl_i.move_en && (idx_i <= ctrl_i.move_idx)) begin
      // take the neighbor's entry; cell zero sees the accessed symbol
      entry_d = left_i;
    end
    match_d = match_q;
    if (ctrl_i.cmp_en) begin
      match_d = in_list && (entry_q == ctrl_i.sym);
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

// ===== rtl/mtf_prio.sv =====
// Two-stage registered priority encoder: first matching cell from the front.
`default_nettype none

module mtf_prio import mtf_pkg::*; (
  input  logic                 clk_i,
  input  logic [MAX_ITEMS-1:0] match_i,
  output logic                 hit_o,
  output logic [IDX_W-1:0]     idx_o
);

  logic [NGRP*GRP_SZ-1:0] match_pad;
  logic [NGRP-1:0]        grp_any_q, grp_any_d;
  logic [GLOC_W-1:0]      grp_loc_q [NGRP];
  logic [GLOC_W-1:0]      grp_loc_d [NGRP];
  logic                   hit_q, hit_d;
  logic [IDX_W-1:0]       idx_q, idx_d;

  assign match_pad = (NGRP*GRP_SZ)'(match_i);

  // stage one: lowest set bit inside each group of cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_d[g] = |match_pad[g*GRP_SZ +: GRP_SZ];
      grp_loc_d[g] = '0;
      for (int k = GRP_SZ - 1; k >= 0; k--) begin
        if (match_pad[g*GRP_SZ + k]) begin
          grp_loc_d[g] = GLOC_W'(k);
        end
      end
    end
  end

  // stage two: lowest group that holds a match
  always_comb begin
    hit_d = |grp_any_q;
    idx_d = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        idx_d = IDX_W'(g * GRP_SZ + int'(grp_loc_q[g]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_any_q <= grp_any_d;
    grp_loc_q <= grp_loc_d;
    hit_q     <= hit_d;
    idx_q     <= idx_d;
  end

  assign hit_o = hit_q;
  assign idx_o = idx_q;

endmodule

`default_nettype wire

// ===== rtl/move_to_front_list_cost.sv =====
// Move-to-front list with running access cost (top level).
//
// Input channel s_axis: tuser carries cmd (0 = load, 1 = access), tdata
// carries the 8-bit symbol. Output channel m_axis: tdata carries position
// (bits 7:0) and total_cost (bits 39:8); tuser carries found.
// Every input transaction produces exactly one output transaction.
// One item is in flight at a time. A load goes through the S_DONE state
// into the output register; an access steps through S_CMP, S_GRP, S_SEL,
// S_MOVE and S_DONE: the cells compare in parallel, a two-stage registered
// priority encoder finds the first match, then the cells shift toward the
// back in S_MOVE while the cost adds up. The next item is taken once the
// result has moved to the output register.
// Reset empties the list and clears the cost total; the list storage
// itself is not cleared and needs no clearing pass.
// When the receiver stalls, the result waits in the output register and a
// further finished result waits in the sequencer, so input stalls at most
// one item later. Loads beyond the list capacity are dropped.
`default_nettype none
`include "assert_macros.svh"

module move_to_front_list_cost import mtf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // symbol[7:0]
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // position[7:0], total_cost[39:8]
  output logic        m_axis_tuser    // found
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_GRP  = 3'd2;
  localparam logic [2:0] S_SEL  = 3'd3;
  localparam logic [2:0] S_MOVE = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [COST_W-1:0] cost_q, cost_d;
  logic [SYM_W-1:0]  sym_q, sym_d;
  logic [POS_W-1:0]  res_pos_q, res_pos_d;
  logic              res_found_q, res_found_d;
  logic              out_valid_q, out_valid_d;
  logic [POS_W-1:0]  out_pos_q, out_pos_d;
  logic              out_found_q, out_found_d;
  logic [COST_W-1:0] out_cost_q, out_cost_d;

  logic              in_acc;
  logic              out_free;
  logic              has_room;
  cell_ctrl_t        ctrl;
  logic [SYM_W-1:0]  entries [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] match_vec;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [31:0]       pos_full;
  logic [COST_W:0]   cost_sum;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign has_room      = fill_q < CNT_W'(MAX_ITEMS);

  assign pos_full = 32'(hit_idx) + 32'd1;
  assign cost_sum = {1'b0, cost_q} + (COST_W+1)'(pos_full);

  always_comb begin
    ctrl.cmp_en   = (state_q == S_CMP);
    ctrl.load_en  = in_acc && (s_axis_tuser == CMD_LOAD) && has_room;
    ctrl.move_en  = (state_q == S_MOVE) && hit;
    ctrl.fill     = fill_q;
    ctrl.move_idx = hit_idx;
    ctrl.sym      = (state_q == S_IDLE) ? s_axis_tdata : sym_q;
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic [SYM_W-1:0] left;
    if (i == 0) begin : g_head
      assign left = ctrl.sym;
    end else begin : g_body
      assign left = entries[i-1];
    end
    mtf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .idx_i   (IDX_W'(i)),
      .left_i  (left),
      .entry_o (entries[i]),
      .match_o (match_vec[i])
    );
  end

  mtf_prio u_prio (
    .clk_i   (clk_i),
    .match_i (match_vec),
    .hit_o   (hit),
    .idx_o   (hit_idx)
  );

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    cost_d      = cost_q;
    sym_d       = sym_q;
    res_pos_d   = res_pos_q;
    res_found_d = res_found_q;
    out_valid_d = out_valid_q;
    out_pos_d   = out_pos_q;
    out_found_d = out_found_q;
    out_cost_d  = out_cost_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          sym_d = s_axis_tdata;
          if (s_axis_tuser == CMD_ACCESS) begin
            state_d = S_CMP;
          end else begin
            if (has_room) begin
              fill_d = fill_q + CNT_W'(1);
            end
            res_pos_d   = '0;
            res_found_d = 1'b0;
            state_d     = S_DONE;
          end
        end
      end
      S_CMP:  state_d = S_GRP;
      S_GRP:  state_d = S_SEL;
      S_SEL:  state_d = S_MOVE;
      S_MOVE: begin
        res_found_d = hit;
        res_pos_d   = '0;
        if (hit) begin
          res_pos_d = (pos_full > 32'd255) ? '1 : pos_full[POS_W-1:0];
          cost_d    = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // hand the result over once the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pos_d   = res_pos_q;
          out_found_d = res_found_q;
          out_cost_d  = cost_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      cost_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cost_q      <= cost_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q       <= sym_d;
    res_pos_q   <= res_pos_d;
    res_found_q <= res_found_d;
    out_pos_q   <= out_pos_d;
    out_found_q <= out_found_d;
    out_cost_q  <= out_cost_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_cost_q, out_pos_q};
  assign m_axis_tuser  = out_found_q;

  `ASSERT_ALWAYS(a_fill_bound, fill_q <= CNT_W'(MAX_ITEMS), "fill count above list capacity")
  `ASSERT_CLK(a_load_grows, ctrl.load_en |=> fill_q == $past(fill_q) + CNT_W'(1), "load lost")
  `ASSERT_CLK(a_cost_mono, 1'b1 |=> cost_q >= $past(cost_q), "cost total decreased")
  `ASSERT_ALWAYS(a_found_pos, !(out_valid_q && out_found_q) || (out_pos_q != '0), "found result with zero position")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the move-to-front list with running access cost.
`timescale 1ns / 100ps

module tb;
  import mtf_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int QUIET_TAIL   = 1100;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_EVERY  = 400;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic              found;
    logic [COST_W-1:0] total_cost;
  } mtf_result_t;

  // Track the list order and cost total; queue the result of each transaction.
  class mtf_cost_tracker;
    logic [SYM_W-1:0]  list_order [MAX_ITEMS];
    int                list_len;
    logic [COST_W-1:0] cost_total;
    mtf_result_t       awaited_results [$];
    int                mismatches;

    function new();
      list_len   = 0;
      cost_total = '0;
      mismatches = 0;
    endfunction

    function void note_item(logic cmd, logic [SYM_W-1:0] sym);
      mtf_result_t     r;
      int              hit_idx;
      longint unsigned sum;
      r       = '0;
      hit_idx = -1;
      if (cmd == CMD_LOAD) begin
        // drop loads into a full list
        if (list_len < MAX_ITEMS) begin
          list_order[list_len] = sym;
          list_len++;
        end
      end else begin
        // first match from the front wins
        for (int i = 0; i < list_len && hit_idx < 0; i++)
          if (list_order[i] == sym) hit_idx = i;
        if (hit_idx >= 0) begin
          for (int j = hit_idx; j > 0; j--) list_order[j] = list_order[j-1];
          list_order[0] = sym;
          r.found    = 1'b1;
          r.position = (hit_idx + 1 > 255) ? 8'hFF : POS_W'(hit_idx + 1);
          sum = longint'(cost_total) + longint'(hit_idx + 1);
          cost_total = (sum > 64'hFFFF_FFFF) ? '1 : sum[COST_W-1:0];
        end
      end
      r.total_cost = cost_total;
      awaited_results.push_back(r);
    endfunction

    function void check_result(logic [POS_W-1:0] pos, logic hit, logic [COST_W-1:0] cost);
      mtf_result_t want;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: position %0d found %0d total_cost %0d", pos, hit, cost);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      if (pos !== want.position) begin
        $error("position: expected %0d, actual %0d", want.position, pos);
        mismatches++;
      end
      if (hit !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, hit);
        mismatches++;
      end
      if (cost !== want.total_cost) begin
        $error("total_cost: expected %0d, actual %0d", want.total_cost, cost);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // symbol[7:0]
  logic        s_axis_tuser  = 1'b0; // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // position[7:0], total_cost[39:8]
  logic        m_axis_tuser;         // found

  mtf_cost_tracker tracker;
  bit              idling_on = 1'b0;
  int              rx_hold   = 0;
  int              quiet_cycles = 0;

  move_to_front_list_cost dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: stall in random bursts while idling is on.
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      rx_hold       <= $urandom_range(0, 12);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        tracker.note_item(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_result(m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[39:8]);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic push_symbol(input logic cmd, input logic [SYM_W-1:0] sym);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      s_axis_tuser  <= 1'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= sym;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Hold the sender until every pending result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.awaited_results.size() != 0) @(posedge clk_i);
  endtask

  int               items_sent;
  int               next_drain;
  int               roll;
  int               pick;
  int               len;
  bit               full;
  logic [SYM_W-1:0] sym;

  initial begin
    tracker = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // access on an empty list, then a short list with a duplicate
    push_symbol(CMD_ACCESS, 8'h00);
    push_symbol(CMD_ACCESS, 8'hFF);
    push_symbol(CMD_LOAD,   8'h00);
    push_symbol(CMD_LOAD,   8'hFF);
    push_symbol(CMD_LOAD,   8'hA5);
    push_symbol(CMD_LOAD,   8'h5A);
    push_symbol(CMD_LOAD,   8'hA5);
    push_symbol(CMD_ACCESS, 8'h00);
    push_symbol(CMD_ACCESS, 8'hA5);
    push_symbol(CMD_ACCESS, 8'hA5);
    push_symbol(CMD_ACCESS, 8'h5A);
    push_symbol(CMD_ACCESS, 8'hA5);
    push_symbol(CMD_ACCESS, 8'hFF);
    push_symbol(CMD_ACCESS, 8'h7E);
    push_symbol(CMD_ACCESS, 8'h81);
    push_symbol(CMD_LOAD,   8'h80);
    push_symbol(CMD_LOAD,   8'h7F);
    push_symbol(CMD_LOAD,   8'h01);
    push_symbol(CMD_ACCESS, 8'h01);
    push_symbol(CMD_ACCESS, 8'hA5);
    drain_results();

    items_sent = 0;
    next_drain = DRAIN_EVERY;
    while (items_sent < RANDOM_ITEMS) begin
      // alternate idle and busy stretches; stay busy at the tail
      idling_on = ((items_sent / 150) % 3 != 2) && (items_sent < QUIET_TAIL);
      len  = tracker.list_len;
      full = (len >= MAX_ITEMS);
      roll = $urandom_range(0, 99);
      if (roll < (full ? 5 : 30)) begin
        if (len > 0 && $urandom_range(0, 3) == 0)
          sym = tracker.list_order[$urandom_range(0, len - 1)];
        else
          sym = SYM_W'($urandom);
        push_symbol(CMD_LOAD, sym);
        if (!full) items_sent++;
      end else begin
        pick = $urandom_range(0, 99);
        if (len == 0 || pick < 15)
          sym = SYM_W'($urandom);
        else if (pick < 35)
          sym = tracker.list_order[$urandom_range(0, (len > 4) ? 3 : len - 1)];
        else if (pick < 45)
          sym = tracker.list_order[len - 1];
        else
          sym = tracker.list_order[$urandom_range(0, len - 1)];
        push_symbol(CMD_ACCESS, sym);
        items_sent++;
      end
      if (items_sent >= next_drain) begin
        next_drain += DRAIN_EVERY;
        drain_results();
      end
    end

    idling_on = 1'b0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.awaited_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (tracker.mismatches == 0 && tracker.awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== move_to_front_list_cost.f =====
+incdir+rtl
rtl/mtf_pkg.sv
rtl/mtf_cell.sv
rtl/mtf_prio.sv
rtl/move_to_front_list_cost.sv
sim/tb.sv
